FILE: design/ttyq_pkg.sv
// Shared types and constants for the tty receive line discipline queue.
// Used by the compare unit, the byte ring and the top level; no dependencies.
`default_nettype none

package ttyq_pkg;

  // Defaults for the top-level parameters.
  localparam int RING_DEPTH_DEF = 256;
  localparam int MAX_READ_DEF   = 64;

  // Fixed field widths.
  localparam int BYTE_W      = 8;
  localparam int MAXC_W      = 7;
  localparam int DEST_W      = 2;
  localparam int LINE_W      = 9;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE   = 8'd10;
  localparam logic [LINE_W-1:0] LINE_COUNT_MAX = 9'd511;

  // Destination codes on the result port.
  localparam logic [DEST_W-1:0] DEST_ECHO = 2'd0;
  localparam logic [DEST_W-1:0] DEST_DATA = 2'd1;
  localparam logic [DEST_W-1:0] DEST_NONE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_CANONICAL    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ECHO_ENABLE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ECHO_NEWLINE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EOL          = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_EOL2         = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ERASE        = 3'd5;

  // Which reference byte the shared comparator tests against.
  typedef enum logic [1:0] {
    CMP_EOL     = 2'd0,
    CMP_EOL2    = 2'd1,
    CMP_ERASE   = 2'd2,
    CMP_NEWLINE = 2'd3
  } cmp_sel_t;

  // Programmable special characters.
  typedef struct packed {
    logic [BYTE_W-1:0] eol;
    logic [BYTE_W-1:0] eol2;
    logic [BYTE_W-1:0] erase;
  } char_set_t;

endpackage

`default_nettype wire

FILE: design/tty_line_discipline_rx_queue.sv
// Receive line discipline queue for a serial port: incoming characters are
// echoed and stored in a byte ring, with line editing in canonical mode, and
// read requests drain the ring as a stream of result words. An item is taken
// when start is high while busy is low; busy then stays high until the item
// is finished. A received character passes the end-of-line, second
// end-of-line and erase compare steps and an action step, plus an erase
// check when it is an erase that has to look at the last stored byte; its
// echo word, if any, is registered in the action step. A read request first
// checks the queue and then returns one data word per cycle; that rate is
// set by the single read port of the ring, whose registered output is fetched
// one address ahead. A read that finds nothing ready gives a single word
// marked as empty. Every result word is shown for exactly one cycle with
// result_strobe high: the receiver cannot hold results off and must take each
// word as it comes. The ring has no clearing pass after reset, since only
// written entries are ever read.
`default_nettype none

module tty_line_discipline_rx_queue
  import ttyq_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MAX_READ   = MAX_READ_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Item port.
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind,
  input  logic [BYTE_W-1:0]      rx_char,
  input  logic [MAXC_W-1:0]      max_count,
  // Configuration write port.
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Result port.
  output logic                   result_strobe,
  output logic [DEST_W-1:0]      dest,
  output logic [BYTE_W-1:0]      byte_out,
  output logic                   last
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  localparam logic [IW-1:0]     IDX_LAST = IW'(RING_DEPTH - 1);
  localparam logic [CW-1:0]     ROOM2    = CW'(RING_DEPTH - 2);
  localparam logic [CW-1:0]     ROOM3    = CW'(RING_DEPTH - 3);
  localparam logic [MAXC_W-1:0] MAXC_SAT = MAXC_W'(MAX_READ);

  // Sequencer states. A received character walks through the three compare
  // steps, acts, then checks an erase; a read checks the queue, streams bytes.
  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_EOL1      = 8'b0000_0010,
    S_EOL2      = 8'b0000_0100,
    S_ERASE     = 8'b0000_1000,
    S_ACT       = 8'b0001_0000,
    S_ERASE_CHK = 8'b0010_0000,
    S_RD_CHECK  = 8'b0100_0000,
    S_RD_DATA   = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic              canonical_mode;
  logic              echo_enable;
  logic              echo_newline;
  logic [BYTE_W-1:0] eol_char;
  logic [BYTE_W-1:0] eol2_char;
  logic [BYTE_W-1:0] erase_char;

  // Queue state.
  logic [IW-1:0]     read_index;
  logic [IW-1:0]     write_index;
  logic [CW-1:0]     stored_count;
  logic [LINE_W-1:0] line_count;

  // Item being worked on.
  logic [BYTE_W-1:0] char_reg;
  logic [MAXC_W-1:0] max_reg;
  logic [MAXC_W-1:0] remaining;
  logic              is_eol;
  logic              is_erase;

  // Ring and comparator hookup.
  logic              ring_wr_en;
  logic [BYTE_W-1:0] ring_wr_data;
  logic              ring_rd_en;
  logic [IW-1:0]     ring_rd_addr;
  logic [BYTE_W-1:0] ring_rd_data;
  cmp_sel_t          cmp_sel;
  logic [BYTE_W-1:0] cmp_a;
  logic              cmp_eq;
  char_set_t         chars;

  logic [IW-1:0]     write_next;
  logic [IW-1:0]     write_prev;
  logic [IW-1:0]     read_next;
  logic              room2;
  logic              room3;
  logic              echo_go;
  logic              erase_go;
  logic              nothing_ready;
  logic [MAXC_W-1:0] maxc_eff;
  logic              rd_last;
  logic              line_done;

  assign busy = (state != S_IDLE);

  assign chars.eol   = eol_char;
  assign chars.eol2  = eol2_char;
  assign chars.erase = erase_char;

  // Ring pointer arithmetic, written to wrap at any depth.
  assign write_next = (write_index == IDX_LAST) ? '0 : write_index + 1'b1;
  assign write_prev = (write_index == '0) ? IDX_LAST : write_index - 1'b1;
  assign read_next  = (read_index == IDX_LAST) ? '0 : read_index + 1'b1;

  assign room2 = (stored_count <= ROOM2);
  assign room3 = (stored_count <= ROOM3);

  // An end-of-line character echoes under its own flag, anything else under
  // the general echo flag.
  assign echo_go  = is_eol ? echo_newline : echo_enable;
  assign erase_go = canonical_mode && !is_eol && is_erase && (stored_count != '0);

  // In canonical mode an end-of-line stores a newline with two free slots,
  // an erase stores nothing, and ordinary bytes need three free slots. Raw
  // mode stores every byte with two free slots.
  always_comb begin
    if (!canonical_mode) begin
      ring_wr_en   = room2;
      ring_wr_data = char_reg;
    end else if (is_eol) begin
      ring_wr_en   = room2;
      ring_wr_data = NEWLINE_CODE;
    end else begin
      ring_wr_en   = !is_erase && room3;
      ring_wr_data = char_reg;
    end
    if (state != S_ACT) begin
      ring_wr_en = 1'b0;
    end
  end

  // The ring's read port is fetched one step ahead: the erase check reads
  // the byte before the write index, and a read streams from read_index.
  always_comb begin
    case (state)
      S_ACT: begin
        ring_rd_en   = erase_go;
        ring_rd_addr = write_prev;
      end
      S_RD_CHECK: begin
        ring_rd_en   = 1'b1;
        ring_rd_addr = read_index;
      end
      S_RD_DATA: begin
        ring_rd_en   = 1'b1;
        ring_rd_addr = read_next;
      end
      default: begin
        ring_rd_en   = 1'b0;
        ring_rd_addr = read_index;
      end
    endcase
  end

  // The comparator tests the received character in three steps, in the
  // order end-of-line, second end-of-line, erase, and tests ring bytes
  // against the newline code.
  always_comb begin
    case (state)
      S_EOL1: begin
        cmp_sel = CMP_EOL;
        cmp_a   = char_reg;
      end
      S_EOL2: begin
        cmp_sel = CMP_EOL2;
        cmp_a   = char_reg;
      end
      S_ERASE: begin
        cmp_sel = CMP_ERASE;
        cmp_a   = char_reg;
      end
      default: begin
        cmp_sel = CMP_NEWLINE;
        cmp_a   = ring_rd_data;
      end
    endcase
  end

  assign maxc_eff      = (max_reg > MAXC_SAT) ? MAXC_SAT : max_reg;
  assign nothing_ready = (stored_count == '0) || (canonical_mode && (line_count == '0)) ||
                         (maxc_eff == '0);

  // A streamed byte ends the read when the request is satisfied, when the
  // ring runs dry, or in canonical mode when it is the stored newline.
  assign rd_last   = (remaining == MAXC_W'(1)) || (stored_count == CW'(1)) ||
                     (canonical_mode && cmp_eq);
  // The whole line has been read when its newline went out or, for a line
  // without a newline, when every stored byte went out.
  assign line_done = canonical_mode && (cmp_eq || (stored_count == CW'(1)));

  ttyq_cmp u_cmp (
    .a     (cmp_a),
    .sel   (cmp_sel),
    .chars (chars),
    .eq    (cmp_eq)
  );

  ttyq_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (write_index),
    .wr_data (ring_wr_data),
    .rd_en   (ring_rd_en),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_rd_data)
  );

  // Item and result payload registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          char_reg <= rx_char;
          max_reg  <= max_count;
        end
      end
      S_EOL1:  is_eol   <= cmp_eq;
      S_EOL2:  is_eol   <= is_eol | cmp_eq;
      S_ERASE: is_erase <= cmp_eq;
      S_ACT: begin
        dest     <= DEST_ECHO;
        byte_out <= char_reg;
        last     <= 1'b1;
      end
      S_RD_CHECK: begin
        remaining <= maxc_eff;
        dest      <= DEST_NONE;
        byte_out  <= '0;
        last      <= 1'b1;
      end
      S_RD_DATA: begin
        remaining <= remaining - 1'b1;
        dest      <= DEST_DATA;
        byte_out  <= ring_rd_data;
        last      <= rd_last;
      end
      default: begin
      end
    endcase
  end

  // Control state, queue state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_strobe  <= 1'b0;
      read_index     <= '0;
      write_index    <= '0;
      stored_count   <= '0;
      line_count     <= '0;
      canonical_mode <= 1'b1;
      echo_enable    <= 1'b1;
      echo_newline   <= 1'b0;
      eol_char       <= 8'd10;
      eol2_char      <= 8'd13;
      erase_char     <= 8'd127;
    end else begin
      result_strobe <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          REG_CANONICAL:    canonical_mode <= cfg_data[0];
          REG_ECHO_ENABLE:  echo_enable    <= cfg_data[0];
          REG_ECHO_NEWLINE: echo_newline   <= cfg_data[0];
          REG_EOL:          eol_char       <= cfg_data;
          REG_EOL2:         eol2_char      <= cfg_data;
          REG_ERASE:        erase_char     <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            state <= kind ? S_RD_CHECK : S_EOL1;
          end
        end
        S_EOL1:  state <= S_EOL2;
        S_EOL2:  state <= S_ERASE;
        S_ERASE: state <= S_ACT;
        S_ACT: begin
          result_strobe <= echo_go;
          if (ring_wr_en) begin
            write_index  <= write_next;
            stored_count <= stored_count + 1'b1;
          end
          // A canonical end-of-line counts a line up to LINE_COUNT_MAX,
          // even when its newline found no room in the ring.
          if (canonical_mode && is_eol && (line_count != LINE_COUNT_MAX)) begin
            line_count <= line_count + 1'b1;
          end
          state <= erase_go ? S_ERASE_CHK : S_IDLE;
        end
        S_ERASE_CHK: begin
          // An erase never reaches back past a completed line.
          if (!cmp_eq) begin
            write_index  <= write_prev;
            stored_count <= stored_count - 1'b1;
          end
          state <= S_IDLE;
        end
        S_RD_CHECK: begin
          if (nothing_ready) begin
            result_strobe <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_RD_DATA;
          end
        end
        S_RD_DATA: begin
          result_strobe <= 1'b1;
          read_index    <= read_next;
          stored_count  <= stored_count - 1'b1;
          if (rd_last) begin
            if (line_done && (line_count != '0)) begin
              line_count <= line_count - 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The fill level never exceeds the ring depth.
  assert property (@(posedge clk) disable iff (rst)
    stored_count <= CW'(RING_DEPTH))
    else $error("ring fill level above depth");

  // An accepted item always makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // The final word of an item is never followed directly by another word.
  assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last) |=> !result_strobe)
    else $error("result word right after a final word");

  // Streaming a byte always has a stored byte behind it.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_DATA) |-> (stored_count != '0))
    else $error("read streamed from an empty ring");

endmodule

`default_nettype wire

FILE: design/ttyq_cmp.sv
// Shared byte comparator of the line discipline sequencer.
// Depends on ttyq_pkg for the select codes and the special character set.
`default_nettype none

module ttyq_cmp
  import ttyq_pkg::*;
(
  input  logic [BYTE_W-1:0] a,
  input  cmp_sel_t          sel,
  input  char_set_t         chars,
  output logic              eq
);

  logic [BYTE_W-1:0] ref_byte;

  always_comb begin
    case (sel)
      CMP_EOL:     ref_byte = chars.eol;
      CMP_EOL2:    ref_byte = chars.eol2;
      CMP_ERASE:   ref_byte = chars.erase;
      CMP_NEWLINE: ref_byte = NEWLINE_CODE;
      default:     ref_byte = NEWLINE_CODE;
    endcase
  end

  assign eq = (a == ref_byte);

endmodule

`default_nettype wire

FILE: design/ttyq_ring.sv
// Byte ring storage: one write port and one read port with registered data.
// Depends on ttyq_pkg for the byte width and the default depth.
`default_nettype none

module ttyq_ring
  import ttyq_pkg::*;
#(
  parameter int DEPTH = RING_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: test/tty_line_discipline_rx_queue_test.sv
// Self-checking testbench for the tty receive line discipline queue.
// Holds its own line discipline predictor in a small scoreboard class;
// depends only on ttyq_pkg and the tty_line_discipline_rx_queue module.
`timescale 1ns / 1ps

module tty_line_discipline_rx_queue_test;
  import ttyq_pkg::*;

  localparam int DEPTH        = RING_DEPTH_DEF;
  localparam int READ_MAX     = MAX_READ_DEF;
  // No correct run goes this long without taking an input word or showing a
  // result word: it stays well above the longest sender gap, the quiet pause
  // before a register write and the time a character keeps the block busy.
  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_WORDS = 130;
  // Enough end-of-line characters to fill the ring with newlines and keep
  // counting lines once nothing more fits.
  localparam int FLOOD_WORDS  = 300;

  // One result word as the block presents it.
  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic [BYTE_W-1:0] data;
    logic              last;
  } result_word_t;

  // One full set of register values.
  typedef struct packed {
    logic              canon;
    logic              echo_on;
    logic              echo_nl;
    logic [BYTE_W-1:0] eol;
    logic [BYTE_W-1:0] eol2;
    logic [BYTE_W-1:0] erase;
  } disc_cfg_t;

  // The scoreboard keeps a private copy of the ring, its indexes, the line
  // count and the registers. Every accepted input word is run through the
  // same line discipline rules, and the result words they cause are queued
  // in due_words until the block shows them.
  class rx_line_tracker;
    bit [BYTE_W-1:0] ring [DEPTH];
    int              head;
    int              tail;
    int              held;
    int              lines;
    bit              canon;
    bit              echo_on;
    bit              echo_nl;
    bit [BYTE_W-1:0] eol;
    bit [BYTE_W-1:0] eol2;
    bit [BYTE_W-1:0] erase;
    result_word_t    due_words[$];
    int              errors;
    int              checked;
    int              items;
    int              reads;
    int              peak_held;
    int              peak_lines;

    function new();
      canon   = 1'b1;
      echo_on = 1'b1;
      echo_nl = 1'b0;
      eol     = 8'd10;
      eol2    = 8'd13;
      erase   = 8'd127;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_CANONICAL:    canon   = val[0];
        REG_ECHO_ENABLE:  echo_on = val[0];
        REG_ECHO_NEWLINE: echo_nl = val[0];
        REG_EOL:          eol     = val;
        REG_EOL2:         eol2    = val;
        REG_ERASE:        erase   = val;
        default: ;
      endcase
    endfunction

    function void push(logic [DEST_W-1:0] d, logic [BYTE_W-1:0] b, logic l);
      result_word_t w;
      w.dest = d;
      w.data = b;
      w.last = l;
      due_words.push_back(w);
    endfunction

    // A byte goes into the ring only while enough slots stay free.
    function void store(logic [BYTE_W-1:0] b, int min_free);
      if (DEPTH - held >= min_free) begin
        ring[tail] = b;
        tail = (tail + 1) % DEPTH;
        held++;
      end
    endfunction

    // Length of the oldest line; without a stored newline it is everything.
    function int line_len();
      for (int t = 0; t < held; t++) begin
        if (ring[(head + t) % DEPTH] == NEWLINE_CODE) return t + 1;
      end
      return held;
    endfunction

    function void take_item(logic k, logic [BYTE_W-1:0] ch, logic [MAXC_W-1:0] mc);
      logic is_eol;
      int   prev;
      int   limit;
      int   len;
      int   n;
      items++;
      if (!k) begin
        is_eol = (ch == eol) || (ch == eol2);
        if ((is_eol && echo_nl) || (!is_eol && echo_on)) push(DEST_ECHO, ch, 1'b1);
        if (!canon) begin
          store(ch, 2);
        end else if (is_eol) begin
          // The line counts even when the ring had no room for its newline.
          store(NEWLINE_CODE, 2);
          if (lines < LINE_COUNT_MAX) lines++;
        end else if (ch == erase) begin
          // Erase never reaches back past a newline.
          if (held > 0) begin
            prev = (tail + DEPTH - 1) % DEPTH;
            if (ring[prev] != NEWLINE_CODE) begin
              tail = prev;
              held--;
            end
          end
        end else begin
          store(ch, 3);
        end
        if (held > peak_held) peak_held = held;
        if (lines > peak_lines) peak_lines = lines;
      end else begin
        reads++;
        limit = (mc > READ_MAX) ? READ_MAX : mc;
        if (held == 0 || (canon && lines == 0) || limit == 0) begin
          push(DEST_NONE, '0, 1'b1);
        end else begin
          len = canon ? line_len() : held;
          n   = (len < limit) ? len : limit;
          for (int i = 0; i < n; i++) begin
            push(DEST_DATA, ring[(head + i) % DEPTH], i == n - 1);
          end
          head = (head + n) % DEPTH;
          held -= n;
          // Only a fully read line is taken off the count.
          if (canon && n == len && lines > 0) lines--;
        end
      end
    endfunction

    function void check_word(logic [DEST_W-1:0] d, logic [BYTE_W-1:0] b, logic l);
      result_word_t w;
      if (due_words.size() == 0) begin
        errors++;
        $error("result word with none expected: dest %0d byte_out %0h last %0d", d, b, l);
        return;
      end
      w = due_words.pop_front();
      checked++;
      if (d !== w.dest) begin
        errors++;
        $error("dest: expected %0d, actual %0d", w.dest, d);
      end
      if (b !== w.data) begin
        errors++;
        $error("byte_out: expected %0h, actual %0h", w.data, b);
      end
      if (l !== w.last) begin
        errors++;
        $error("last: expected %0d, actual %0d", w.last, l);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   kind;
  logic [BYTE_W-1:0]      rx_char;
  logic [MAXC_W-1:0]      max_count;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  wire                    busy;
  wire                    result_strobe;
  wire [DEST_W-1:0]       dest;
  wire [BYTE_W-1:0]       byte_out;
  wire                    last;

  rx_line_tracker tracker;
  disc_cfg_t      cur_cfg;
  int             taken = 0;
  int             idle_cycles = 0;
  int             burst_left;
  int             settings_used;

  tty_line_discipline_rx_queue i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .rx_char       (rx_char),
    .max_count     (max_count),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .dest          (dest),
    .byte_out      (byte_out),
    .last          (last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Everything is sampled at the rising edge, while inputs only move at the
  // falling edge. Result words are checked before a new input word is noted,
  // so expectations always stay in arrival order.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) tracker.check_word(dest, byte_out, last);
      if (start && !busy) begin
        tracker.take_item(kind, rx_char, max_count);
        taken <= taken + 1;
      end
    end
  end

  // Watchdog: any accepted input or result word restarts the count.
  always @(posedge clk) begin
    if (rst || result_strobe || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("no word moved for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drop start for a while; the payload ports carry noise meanwhile.
  task automatic pause_sender(int cycles);
    start     <= 1'b0;
    kind      <= 1'($urandom);
    rx_char   <= 8'($urandom);
    max_count <= 7'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  // The sender works in bursts. Short gaps land on every cycle of a character
  // or a short read, long ones let the block go fully idle after a character,
  // and some bursts are long enough to keep start high across many words.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 4) == 0) pause_sender($urandom_range(15, 40));
      else pause_sender($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  // Present one input word from a falling edge and hold it until the block
  // takes it, then paces the sender from the falling edge after acceptance.
  task automatic drive_word(logic k, logic [BYTE_W-1:0] ch, logic [MAXC_W-1:0] mc);
    int seen;
    seen = taken;
    start     <= 1'b1;
    kind      <= k;
    rx_char   <= ch;
    max_count <= mc;
    wait (taken != seen);
    @(negedge clk);
    pace();
  endtask

  task automatic type_char(logic [BYTE_W-1:0] ch);
    drive_word(1'b0, ch, 7'($urandom));
  endtask

  task automatic ask(logic [MAXC_W-1:0] mc);
    drive_word(1'b1, 8'($urandom), mc);
  endtask

  // Wait until the block has shown every expected word and gone idle.
  task automatic settle();
    start <= 1'b0;
    while (tracker.due_words.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    tracker.set_reg(idx, val);
    @(negedge clk);
  endtask

  // Writes all six registers back to back. The one-bit registers get random
  // upper data bits, which the block must ignore.
  task automatic write_all(disc_cfg_t c);
    write_reg(REG_CANONICAL, {7'($urandom), c.canon});
    write_reg(REG_ECHO_ENABLE, {7'($urandom), c.echo_on});
    write_reg(REG_ECHO_NEWLINE, {7'($urandom), c.echo_nl});
    write_reg(REG_EOL, c.eol);
    write_reg(REG_EOL2, c.eol2);
    write_reg(REG_ERASE, c.erase);
    cfg_write <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_special();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return NEWLINE_CODE;
      3:       return 8'd13;
      4:       return 8'd127;
      default: return 8'($urandom);
    endcase
  endfunction

  // Read lengths: mostly legal, with zero, the maximum, values past the
  // maximum and very short reads that split lines.
  function automatic logic [MAXC_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'($urandom_range(65, 127));
      2:       return 7'(READ_MAX);
      3, 4, 5: return 7'($urandom_range(1, 4));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic disc_cfg_t random_cfg();
    disc_cfg_t c;
    c.canon   = ($urandom_range(0, 2) != 0);
    c.echo_on = 1'($urandom);
    c.echo_nl = 1'($urandom);
    c.eol     = pick_special();
    c.eol2    = pick_special();
    c.erase   = pick_special();
    return c;
  endfunction

  // A typed line: random bytes with some erases, usually closed by one of
  // the end-of-line codes, then one or two reads.
  task automatic send_line();
    int n;
    n = $urandom_range(0, 12);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) type_char(cur_cfg.erase);
      else type_char(8'($urandom));
    end
    if ($urandom_range(0, 7) != 0) type_char($urandom_range(0, 1) ? cur_cfg.eol : cur_cfg.eol2);
    repeat ($urandom_range(1, 2)) ask(pick_count());
  endtask

  // Random phases: each starts from a fresh random register setting, and
  // most of the traffic is typed lines, the rest fully random words.
  task automatic run_random(int words);
    int goal;
    int phase_end;
    goal = tracker.items + words;
    while (tracker.items < goal) begin
      settle();
      write_all(random_cfg());
      phase_end = tracker.items + $urandom_range(40, 80);
      if (phase_end > goal) phase_end = goal;
      while (tracker.items < phase_end) begin
        if ($urandom_range(0, 9) < 7) begin
          send_line();
        end else begin
          repeat ($urandom_range(1, 3)) drive_word(1'($urandom), 8'($urandom), 7'($urandom));
        end
      end
    end
  endtask

  // Overload: a stream of end-of-line characters fills the ring with
  // newlines and keeps counting lines once nothing more fits. A few erases
  // and plain bytes hit the full ring.
  task automatic run_flood();
    disc_cfg_t c;
    c.canon   = 1'b1;
    c.echo_on = 1'($urandom);
    c.echo_nl = 1'b0;
    c.eol     = NEWLINE_CODE;
    c.eol2    = 8'd13;
    c.erase   = 8'd127;
    settle();
    write_all(c);
    repeat (FLOOD_WORDS) begin
      case ($urandom_range(0, 19))
        0, 1:    type_char(cur_cfg.erase);
        2:       type_char(8'($urandom));
        default: type_char($urandom_range(0, 1) ? cur_cfg.eol : cur_cfg.eol2);
      endcase
    end
    repeat (6) ask(pick_count());
  endtask

  initial begin
    disc_cfg_t c;
    tracker       = new();
    rst           = 1'b1;
    start         = 1'b0;
    kind          = 1'b0;
    rx_char       = '0;
    max_count     = '0;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    burst_left    = 0;
    settings_used = 1;
    cur_cfg.canon   = 1'b1;
    cur_cfg.echo_on = 1'b1;
    cur_cfg.echo_nl = 1'b0;
    cur_cfg.eol     = 8'd10;
    cur_cfg.eol2    = 8'd13;
    cur_cfg.erase   = 8'd127;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset settings: canonical, echo on.
    ask(7'd1);              // nothing stored yet
    type_char(8'h00);
    type_char(8'hFF);
    type_char(8'd127);      // erase takes back the last byte
    type_char(8'h61);
    type_char(8'd13);       // second end-of-line code, not echoed
    type_char(8'd127);      // erase stops at the newline
    ask(7'd0);              // zero length reads nothing
    ask(7'd127);            // length beyond the maximum, whole line
    ask(7'd64);             // queue is empty again
    type_char(8'd127);      // erase on an empty ring
    type_char(8'h55);
    type_char(8'd10);
    ask(7'd1);              // partial line leaves the count alone
    ask(7'd65);

    // Raw mode: no editing, end-of-line codes echoed only by echo_newline.
    settle();
    c.canon   = 1'b0;
    c.echo_on = 1'b0;
    c.echo_nl = 1'b1;
    c.eol     = 8'd10;
    c.eol2    = 8'd13;
    c.erase   = 8'd127;
    write_all(c);
    type_char(NEWLINE_CODE);
    type_char(8'd127);
    type_char(8'h80);
    ask(7'd2);
    ask(7'd64);

    // Extreme codes: the erase code equals the first end-of-line code, so it
    // never erases, and a plain newline byte still ends a stored line.
    settle();
    c.canon   = 1'b1;
    c.echo_on = 1'b1;
    c.echo_nl = 1'b1;
    c.eol     = 8'h00;
    c.eol2    = 8'hFF;
    c.erase   = 8'h00;
    write_all(c);
    type_char(8'h00);
    type_char(8'hFF);
    type_char(NEWLINE_CODE);
    ask(7'd64);
    ask(7'd64);
    ask(7'd64);             // bytes stored but no line counted

    run_random(RANDOM_WORDS / 2);
    run_flood();
    run_random(RANDOM_WORDS - RANDOM_WORDS / 2);

    settle();
    repeat (12) @(negedge clk);
    if (tracker.due_words.size() != 0) begin
      tracker.errors++;
      $error("%0d expected result words never arrived", tracker.due_words.size());
    end
    $display("Run covered %0d input words (%0d read requests) under %0d register settings.",
             tracker.items, tracker.reads, settings_used);
    $display("Compared %0d result words; ring filled to %0d bytes, line count reached %0d.",
             tracker.checked, tracker.peak_held, tracker.peak_lines);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ttyq_pkg.sv
design/ttyq_cmp.sv
design/ttyq_ring.sv
design/tty_line_discipline_rx_queue.sv
test/tty_line_discipline_rx_queue_test.sv
